[design/tof_iq_to_phase_amplitude_macros.svh]
// Assertion macros for the I/Q to phase block
`ifndef TOF_IQ_TO_PHASE_AMPLITUDE_MACROS_SVH
`define TOF_IQ_TO_PHASE_AMPLITUDE_MACROS_SVH
// implication checked every clock, off during reset
`define TIPA_ASSERT_IMP(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");
// next-cycle implication
`define TIPA_ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");
`endif

[design/tipa_pkg.sv]
// ----------------------------------------------------------------------------
// tipa_pkg
// Shared constants and angle table of the I/Q to phase and amplitude block.
// ----------------------------------------------------------------------------
package tipa_pkg;
  localparam int unsigned AngleTabLen = 24;
  localparam logic [31:0] InvGain = 32'd2608131496;

  localparam logic [2:0] RegRoiX    = 3'd0;
  localparam logic [2:0] RegRoiY    = 3'd1;
  localparam logic [2:0] RegMaxW    = 3'd2;
  localparam logic [2:0] RegOutW    = 3'd3;
  localparam logic [2:0] RegOutH    = 3'd4;
  localparam logic [2:0] RegRowsM   = 3'd5;
  localparam logic [2:0] RegColsM   = 3'd6;
  localparam logic [2:0] RegOffEn   = 3'd7;

  function automatic logic [31:0] angle_entry(input int unsigned k);
    logic [31:0] t [AngleTabLen] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
      32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
      32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
      32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81};
    angle_entry = (k < AngleTabLen) ? t[k] : t[AngleTabLen-1];
  endfunction
endpackage

[design/tipa_ram.sv]
// ----------------------------------------------------------------------------
// tipa_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module tipa_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    if (re_i) rdata_o <= mem_q[raddr_i];
  end
endmodule

[design/tipa_cordic.sv]
// ----------------------------------------------------------------------------
// tipa_cordic
// Pipelined vectoring CORDIC: one stage per register, then gain multiply.
// ----------------------------------------------------------------------------
`include "tof_iq_to_phase_amplitude_macros.svh"
module tipa_cordic #(
  parameter int unsigned PhaseBits = 12,
  parameter int unsigned Stages    = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic signed [15:0]   i_i,
  input  logic signed [15:0]   q_i,
  output logic                 valid_o,
  output logic [PhaseBits-1:0] phase_o,
  output logic [15:0]          amp_o
);
  // x grows by at most gain*sqrt2; 16+16 bits of data plus headroom
  localparam int unsigned XW = 36;
  localparam int unsigned L = Stages + 2;

  logic signed [XW-1:0] x_q [Stages+1];
  logic signed [XW-1:0] y_q [Stages+1];
  logic [31:0]          z_q [Stages+1];
  logic                 zero_q [Stages+1];
  logic [L-1:0]         v_q;
  logic [PhaseBits-1:0] ph_q;
  logic                 zf_q;
  logic [64:0]          prod_q;
  logic signed [XW-1:0] x0, y0;

  always_comb begin
    x0 = XW'({{(XW-16){i_i[15]}}, i_i}) <<< 16;
    y0 = XW'({{(XW-16){q_i[15]}}, q_i}) <<< 16;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v_q <= '0;
    else if (en_i) v_q <= {v_q[L-2:0], valid_i};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      zero_q[0] <= (i_i == 16'sd0) && (q_i == 16'sd0);
      if (i_i[15]) begin
        x_q[0] <= -x0; y_q[0] <= -y0; z_q[0] <= 32'h8000_0000;
      end else begin
        x_q[0] <= x0; y_q[0] <= y0; z_q[0] <= '0;
      end
      for (int k = 0; k < Stages; k++) begin
        zero_q[k+1] <= zero_q[k];
        if (!y_q[k][XW-1]) begin
          x_q[k+1] <= x_q[k] + (y_q[k] >>> k);
          y_q[k+1] <= y_q[k] - (x_q[k] >>> k);
          z_q[k+1] <= z_q[k] + tipa_pkg::angle_entry(k);
        end else begin
          x_q[k+1] <= x_q[k] - (y_q[k] >>> k);
          y_q[k+1] <= y_q[k] + (x_q[k] >>> k);
          z_q[k+1] <= z_q[k] - tipa_pkg::angle_entry(k);
        end
      end
      ph_q <= zero_q[Stages] ? '0 : z_q[Stages][31 -: PhaseBits];
      zf_q <= zero_q[Stages] || x_q[Stages][XW-1] || (x_q[Stages] == '0);
      prod_q <= 65'(x_q[Stages][32:0]) * 65'(tipa_pkg::InvGain);
    end
  end
  // x of a valid vector stays below 2^33 (|v|*gain*2^16)
  assign valid_o = v_q[L-1];
  assign amp_o   = zf_q ? 16'd0 :
                   ((prod_q[64:48] > 17'h0FFFF) ? 16'hFFFF : prod_q[63:48]);
  assign phase_o = ph_q;

  `TIPA_ASSERT_NEXT(a_hold, clk_i, rst_ni, !en_i, $stable(v_q))
  `TIPA_ASSERT_NEXT(a_valid_hold, clk_i, rst_ni, !en_i && valid_o, valid_o)
  `TIPA_ASSERT_NEXT(a_phase_hold, clk_i, rst_ni, !en_i && valid_o, $stable(phase_o))
endmodule

[design/tof_iq_to_phase_amplitude.sv]
// ----------------------------------------------------------------------------
// tof_iq_to_phase_amplitude
// I/Q samples to phase and amplitude with per-pixel phase offset.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i/in_stall_o): func 0 writes one offset store
// entry and gives no result; func 1 is a pixel in raster order.
// Output channel (out_valid_o/out_stall_i): phase, amplitude, last_pixel.
// Config channel (cfg_valid_i/cfg_ready_o): index and data; any valid
// index restarts the frame. Write only while idle.
// Pixels pass the CORDIC input, rotation stage and output registers.
// Throughput: one item per cycle; the CORDIC pipeline and the offset RAM
// read advance together, one stage a clock. The cycle after a config
// write (and the first cycle after reset) the input stalls while the
// frame origin is reloaded.
// The pipeline holds while the output stalls (the whole pipeline freezes,
// in_stall_o follows out_stall_i). Load writes use the RAM write port and
// pass while a pixel is in flight; a pixel's offset read happens at its
// beat. Read each entry only after it was written; not enforced by the block.
// Reset sets config defaults and counters; the offset store is not cleared.
module tof_iq_to_phase_amplitude #(
  parameter int unsigned OFFSET_ENTRIES = 131072,
  parameter int unsigned PHASE_BITS     = 12,
  parameter int unsigned CORDIC_STAGES  = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [2:0]           cfg_index_i,
  input  logic [10:0]          cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 func_i,
  input  logic [16:0]          offset_addr_i,
  input  logic signed [15:0]   offset_value_i,
  input  logic signed [15:0]   i_value_i,
  input  logic signed [15:0]   q_value_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [PHASE_BITS-1:0] phase_o,
  output logic [15:0]          amplitude_o,
  output logic                 last_pixel_o
);
  localparam int unsigned AW = $clog2(OFFSET_ENTRIES);
  localparam int unsigned L  = CORDIC_STAGES + 2;

  logic [9:0] roi_x_q, roi_y_q;
  logic [10:0] mfw_q, ow_q, oh_q;
  logic [4:0] rm_q, cm_q;
  logic offen_q;
  logic [9:0] row_q, col_q;
  logic [AW-1:0] rbase_q, paddr_q;
  logic restart_q;

  logic en, acc, pix;
  assign en = !out_stall_i;
  assign in_stall_o = out_stall_i || restart_q;
  assign cfg_ready_o = 1'b1;
  assign acc = in_valid_i && !in_stall_o;
  assign pix = acc && func_i;

  logic [AW-1:0] origin;
  logic [20:0] orig_full;
  always_comb begin
    orig_full = {11'd0, roi_y_q} * {10'd0, mfw_q} + {11'd0, roi_x_q};
    origin = AW'(orig_full);
  end

  logic [10:0] w, h;
  always_comb begin
    w = (ow_q == '0) ? 11'd1 : ((ow_q > 11'd1024) ? 11'd1024 : ow_q);
    h = (oh_q == '0) ? 11'd1 : ((oh_q > 11'd1024) ? 11'd1024 : oh_q);
  end

  logic last_d, col_wrap;
  logic [15:0] row_step;
  assign col_wrap = (11'(col_q) + 11'd1) >= w;
  assign last_d   = ((11'(row_q) + 11'd1) >= h) && col_wrap;
  assign row_step = {11'd0, rm_q} * {5'd0, mfw_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      roi_x_q <= '0; roi_y_q <= '0; mfw_q <= 11'd320; ow_q <= 11'd320;
      oh_q <= 11'd240; rm_q <= 5'd1; cm_q <= 5'd1; offen_q <= 1'b0;
      row_q <= '0; col_q <= '0; rbase_q <= '0; paddr_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        tipa_pkg::RegRoiX:  roi_x_q <= cfg_data_i[9:0];
        tipa_pkg::RegRoiY:  roi_y_q <= cfg_data_i[9:0];
        tipa_pkg::RegMaxW:  mfw_q   <= cfg_data_i;
        tipa_pkg::RegOutW:  ow_q    <= cfg_data_i;
        tipa_pkg::RegOutH:  oh_q    <= cfg_data_i;
        tipa_pkg::RegRowsM: rm_q    <= cfg_data_i[4:0];
        tipa_pkg::RegColsM: cm_q    <= cfg_data_i[4:0];
        tipa_pkg::RegOffEn: offen_q <= cfg_data_i[0];
        default: ;
      endcase
      // restart next cycle via the flag below
      row_q <= '0; col_q <= '0;
    end else if (restart_q) begin
      rbase_q <= origin; paddr_q <= origin;
    end else if (pix) begin
      if (col_wrap) begin
        col_q <= '0;
        if (last_d) begin
          row_q <= '0; rbase_q <= origin; paddr_q <= origin;
        end else begin
          row_q <= row_q + 10'd1;
          rbase_q <= rbase_q + AW'(row_step);
          paddr_q <= rbase_q + AW'(row_step);
        end
      end else begin
        col_q <= col_q + 10'd1;
        paddr_q <= paddr_q + AW'(cm_q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) restart_q <= 1'b1;
    else restart_q <= cfg_valid_i;
  end

  logic [15:0] rdata;
  tipa_ram #(.Width(16), .Depth(OFFSET_ENTRIES)) u_ram (
    .clk_i  (clk_i),
    .we_i   (acc && !func_i),
    .waddr_i(AW'(offset_addr_i)),
    .wdata_i(offset_value_i),
    .re_i   (pix),
    .raddr_i(paddr_q),
    .rdata_o(rdata)
  );

  // offset and flags delayed alongside the CORDIC; read data holds while
  // stalled since no new read starts then
  logic signed [15:0] off_q [L-1];
  logic [L-1:0] last_q;
  logic [L-1:0] pv_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) pv_q <= '0;
    else if (en) pv_q <= {pv_q[L-2:0], pix};
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      last_q <= {last_q[L-2:0], last_d};
      off_q[0] <= (pv_q[0]) ? rdata : off_q[0];
      for (int k = 1; k < L-1; k++) off_q[k] <= off_q[k-1];
    end
  end

  logic cv;
  logic [PHASE_BITS-1:0] cph;
  logic [15:0] camp;
  tipa_cordic #(.PhaseBits(PHASE_BITS), .Stages(CORDIC_STAGES)) u_cordic (
    .clk_i(clk_i), .rst_ni(rst_ni), .en_i(en), .valid_i(pix),
    .i_i(i_value_i), .q_i(q_value_i),
    .valid_o(cv), .phase_o(cph), .amp_o(camp)
  );

  logic signed [17:0] diff;
  always_comb begin
    diff = 18'($signed({1'b0, cph})) - 18'(off_q[L-2]);
    if (!offen_q) phase_o = cph;
    else if (diff < 0) phase_o = '0;
    else if (diff > 18'sd0 + 18'(2**PHASE_BITS - 1)) phase_o = '1;
    else phase_o = PHASE_BITS'(diff);
  end
  assign out_valid_o  = cv;
  assign amplitude_o  = camp;
  assign last_pixel_o = last_q[L-1];

  `TIPA_ASSERT_IMP(a_valid_pipe, clk_i, rst_ni, out_valid_o, pv_q[L-1])
  `TIPA_ASSERT_NEXT(a_stall_hold, clk_i, rst_ni, out_valid_o && out_stall_i,
    out_valid_o)
  `TIPA_ASSERT_IMP(a_restart, clk_i, rst_ni, cfg_valid_i, cfg_ready_o)
endmodule
